/* src/outstanding_request_tracker_defines.svh */
// ----------------------------------------------------------------------------
// Outstanding request tracker assertion macros
// Shared property wrappers for the tracker's checker.
// ----------------------------------------------------------------------------
`ifndef OUTSTANDING_REQUEST_TRACKER_DEFINES_SVH
`define OUTSTANDING_REQUEST_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define ORT_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define ORT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ort_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Outstanding request tracker package
// Entry, result and control types plus fixed codes and reset values.
// ----------------------------------------------------------------------------
package ort_pkg;

   localparam int unsigned MAX_OUT = 16;       // most expiries reported per scan
   localparam logic [15:0] DEFAULT_TIMEOUT_RESET = 16'd5000;
   localparam logic [15:0] SCAN_INTERVAL_RESET   = 16'd1000;

   typedef enum logic [1:0] {
      OP_SEND     = 2'd0,
      OP_RESPONSE = 2'd1,
      OP_TICK     = 2'd2
   } ort_opcode_type;

   typedef enum logic [2:0] {
      STATUS_TRACKED   = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_UNTRACKED = 3'd2,
      STATUS_MATCHED   = 3'd3,
      STATUS_UNMATCHED = 3'd4,
      STATUS_EXPIRED   = 3'd5
   } ort_status_type;

   typedef enum logic [0:0] {
      CSR_DEFAULT_TIMEOUT = 1'd0,
      CSR_SCAN_INTERVAL   = 1'd1
   } ort_csr_type;

   typedef struct packed {
      logic [4:0]  instance_id;
      logic [5:0]  kind;
      logic [7:0]  command;
      logic [31:0] deadline;
      logic [15:0] context_h;
   } ort_entry_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  instance_id;
      logic [5:0]  kind;
      logic [7:0]  command;
      logic [15:0] context_h;
      logic        last;
   } ort_rsp_type;

   // pop: every cell takes its upper neighbour; push: append at the tail
   typedef struct packed {
      logic pop;
      logic push;
   } ort_chain_ctrl_type;

endpackage

/* src/outstanding_request_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Outstanding request tracker
// Insertion-ordered table of outstanding requests with match and timeout.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): send, response or 1 ms tick, taken on valid
//    with stall low. Result channel (rsp_*): one registered result slot.
//  - csr_*: default timeout (index 0) and scan interval (index 1), write
//    only while idle.
//  - A send (tracked, full or untracked) gives its registered result the
//    cycle after it is taken. A tick without a scan leaves the tracker idle.
//  - A response rotates the table once through the head cell, then gives
//    its result. A scan also rotates the table once, held up while the
//    receiver holds stall while expiries are reported.
//  - The cell chain rotates one entry per cycle past the head, except while
//    a scan waits on a stalled expiry; req_stall stays high for the whole
//    rotation and its wrap-up.
//  - Reset empties the table, restarts the id counter, clock and scan
//    countdown, and loads the register reset values. No clearing pass.
//  - While rsp_stall holds a result, req_stall is high and the scan halts
//    before reporting the next expiry.
// ----------------------------------------------------------------------------
module outstanding_request_tracker #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic        req_is_request,
   input  logic [5:0]  req_msg_kind,
   input  logic [7:0]  req_command_code,
   input  logic [4:0]  req_instance_id,
   input  logic [15:0] req_timeout_ms,
   input  logic [15:0] req_caller_context,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_out_instance_id,
   output logic [5:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_command,
   output logic [15:0] rsp_out_context,
   output logic        rsp_last,
   // configuration
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam int unsigned NW = $clog2(ort_pkg::MAX_OUT + 1);

   typedef enum logic {ST_IDLE, ST_ROTATE} state_type;
   typedef enum logic {MODE_MATCH, MODE_SCAN} mode_type;

   // cell chain
   logic                        cell_valid [ENTRIES];
   ort_pkg::ort_entry_type      cell_entry [ENTRIES];
   ort_pkg::ort_chain_ctrl_type chain_ctrl;
   ort_pkg::ort_entry_type      push_entry;

   // control state
   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        step_ff, step_in;
   logic [NW-1:0]        nexp_ff, nexp_in;
   logic [31:0]          now_ff, now_in;
   logic [15:0]          countdown_ff, countdown_in;
   logic [4:0]           next_id_ff, next_id_in;
   logic [15:0]          dflt_tmo_ff, dflt_tmo_in;
   logic [15:0]          scan_ivl_ff, scan_ivl_in;
   logic                 held_valid_ff, held_valid_in;
   ort_pkg::ort_rsp_type held_ff, held_in;
   logic [4:0]           key_id_ff, key_id_in;
   logic [5:0]           key_kind_ff, key_kind_in;
   logic [7:0]           key_cmd_ff, key_cmd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ort_pkg::ort_rsp_type rsp_ff, rsp_in;

   logic out_free;
   logic req_accept;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;

   genvar gi;
   generate
      for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
         logic                   prev_v;
         logic                   next_v;
         ort_pkg::ort_entry_type next_e;
         if (gi == 0) begin : g_head
            assign prev_v = 1'b1;
         end else begin : g_body
            assign prev_v = cell_valid[gi-1];
         end
         if (gi == ENTRIES - 1) begin : g_tail
            assign next_v = 1'b0;
            assign next_e = push_entry;
         end else begin : g_mid
            assign next_v = cell_valid[gi+1];
            assign next_e = cell_entry[gi+1];
         end
         ort_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (chain_ctrl),
            .push_entry (push_entry),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_entry (next_e),
            .valid      (cell_valid[gi]),
            .entry      (cell_entry[gi])
         );
      end
   endgenerate

   always_comb begin
      logic [15:0]            tmo_sel;
      logic [15:0]            ivl;
      logic [15:0]            cd_next;
      logic [31:0]            age;
      logic                   expired;
      logic                   hit;
      ort_pkg::ort_entry_type head;

      head    = cell_entry[0];
      tmo_sel = (req_timeout_ms != 16'd0) ? req_timeout_ms : dflt_tmo_ff;
      ivl     = (scan_ivl_ff != 16'd0) ? scan_ivl_ff : 16'd1;
      cd_next = ((countdown_ff == 16'd0) ? ivl : countdown_ff) - 16'd1;
      age     = now_ff - head.deadline;
      expired = !age[31] && (nexp_ff < NW'(ort_pkg::MAX_OUT));
      hit     = !held_valid_ff && head.instance_id == key_id_ff
                && head.kind == key_kind_ff && head.command == key_cmd_ff;

      state_in      = state_ff;
      mode_in       = mode_ff;
      fill_in       = fill_ff;
      step_in       = step_ff;
      nexp_in       = nexp_ff;
      now_in        = now_ff;
      countdown_in  = countdown_ff;
      next_id_in    = next_id_ff;
      dflt_tmo_in   = dflt_tmo_ff;
      scan_ivl_in   = scan_ivl_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      key_id_in     = key_id_ff;
      key_kind_in   = key_kind_ff;
      key_cmd_in    = key_cmd_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      chain_ctrl    = '0;

      // new entry while idle, head re-append while rotating
      if (state_ff == ST_ROTATE) begin
         push_entry = head;
      end else begin
         push_entry.instance_id = next_id_ff;
         push_entry.kind        = req_msg_kind;
         push_entry.command     = req_command_code;
         push_entry.deadline    = now_ff + 32'(tmo_sel);
         push_entry.context_h   = req_caller_context;
      end

      if (csr_write_enable) begin
         case (csr_index)
            ort_pkg::CSR_DEFAULT_TIMEOUT: dflt_tmo_in = csr_write_data;
            ort_pkg::CSR_SCAN_INTERVAL:   scan_ivl_in = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_opcode)
                  ort_pkg::OP_SEND: begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.kind       = req_msg_kind;
                     rsp_in.command    = req_command_code;
                     rsp_in.context_h  = req_caller_context;
                     rsp_in.last       = 1'b1;
                     if (!req_is_request) begin
                        rsp_in.status      = ort_pkg::STATUS_UNTRACKED;
                        rsp_in.instance_id = 5'd0;
                     end else begin
                        rsp_in.instance_id = next_id_ff;
                        next_id_in         = next_id_ff + 5'd1;
                        if (fill_ff == CW'(ENTRIES)) begin
                           rsp_in.status = ort_pkg::STATUS_FULL;
                        end else begin
                           rsp_in.status   = ort_pkg::STATUS_TRACKED;
                           chain_ctrl.push = 1'b1;
                           fill_in         = fill_ff + CW'(1);
                        end
                     end
                  end
                  ort_pkg::OP_RESPONSE: begin
                     key_id_in     = req_instance_id;
                     key_kind_in   = req_msg_kind;
                     key_cmd_in    = req_command_code;
                     held_valid_in = 1'b0;
                     step_in       = fill_ff;
                     mode_in       = MODE_MATCH;
                     state_in      = ST_ROTATE;
                  end
                  ort_pkg::OP_TICK: begin
                     now_in       = now_ff + 32'd1;
                     countdown_in = cd_next;
                     if (cd_next == 16'd0) begin
                        held_valid_in = 1'b0;
                        nexp_in       = '0;
                        step_in       = fill_ff;
                        mode_in       = MODE_SCAN;
                        state_in      = ST_ROTATE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ROTATE: begin
            if (step_ff == '0) begin
               // wrap-up: final result of this request, if any
               if (held_valid_ff) begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = held_ff;
                     rsp_in.last  = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end else if (mode_ff == MODE_MATCH) begin
                  if (out_free) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.status      = ort_pkg::STATUS_UNMATCHED;
                     rsp_in.instance_id = key_id_ff;
                     rsp_in.kind        = key_kind_ff;
                     rsp_in.command     = key_cmd_ff;
                     rsp_in.context_h   = 16'd0;
                     rsp_in.last        = 1'b1;
                     state_in           = ST_IDLE;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (mode_ff == MODE_MATCH) begin
               chain_ctrl.pop = 1'b1;
               step_in        = step_ff - CW'(1);
               if (hit) begin
                  held_valid_in       = 1'b1;
                  held_in.status      = ort_pkg::STATUS_MATCHED;
                  held_in.instance_id = head.instance_id;
                  held_in.kind        = head.kind;
                  held_in.command     = head.command;
                  held_in.context_h   = head.context_h;
                  held_in.last        = 1'b1;
                  fill_in             = fill_ff - CW'(1);
               end else begin
                  chain_ctrl.push = 1'b1;
               end
            end else if (!expired) begin
               chain_ctrl.pop  = 1'b1;
               chain_ctrl.push = 1'b1;
               step_in         = step_ff - CW'(1);
            end else if (!held_valid_ff || out_free) begin
               // previous expiry goes out now that a later one exists
               if (held_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = held_ff;
                  rsp_in.last  = 1'b0;
               end
               held_valid_in       = 1'b1;
               held_in.status      = ort_pkg::STATUS_EXPIRED;
               held_in.instance_id = head.instance_id;
               held_in.kind        = head.kind;
               held_in.command     = head.command;
               held_in.context_h   = head.context_h;
               held_in.last        = 1'b0;
               nexp_in             = nexp_ff + NW'(1);
               fill_in             = fill_ff - CW'(1);
               chain_ctrl.pop      = 1'b1;
               step_in             = step_ff - CW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_MATCH;
         fill_ff       <= '0;
         step_ff       <= '0;
         nexp_ff       <= '0;
         now_ff        <= 32'd0;
         countdown_ff  <= 16'd0;
         next_id_ff    <= 5'd0;
         dflt_tmo_ff   <= ort_pkg::DEFAULT_TIMEOUT_RESET;
         scan_ivl_ff   <= ort_pkg::SCAN_INTERVAL_RESET;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         fill_ff       <= fill_in;
         step_ff       <= step_in;
         nexp_ff       <= nexp_in;
         now_ff        <= now_in;
         countdown_ff  <= countdown_in;
         next_id_ff    <= next_id_in;
         dflt_tmo_ff   <= dflt_tmo_in;
         scan_ivl_ff   <= scan_ivl_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      key_id_ff   <= key_id_in;
      key_kind_ff <= key_kind_in;
      key_cmd_ff  <= key_cmd_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_out_instance_id = rsp_ff.instance_id;
   assign rsp_out_kind        = rsp_ff.kind;
   assign rsp_out_command     = rsp_ff.command;
   assign rsp_out_context     = rsp_ff.context_h;
   assign rsp_last            = rsp_ff.last;

endmodule

/* src/ort_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker table cell
// One table slot; shifts down on pop and takes the new entry at the tail.
// ----------------------------------------------------------------------------
module ort_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  ort_pkg::ort_chain_ctrl_type ctrl,
   input  ort_pkg::ort_entry_type      push_entry,
   input  logic                        prev_valid,
   input  logic                        next_valid,
   input  ort_pkg::ort_entry_type      next_entry,
   output logic                        valid,
   output ort_pkg::ort_entry_type      entry
);

   logic                   valid_ff, valid_in;
   ort_pkg::ort_entry_type entry_ff, entry_in;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ctrl.pop) begin
         valid_in = next_valid;
         entry_in = next_entry;
         // tail after the shift is the last valid cell before it
         if (ctrl.push && valid_ff && !next_valid) begin
            valid_in = 1'b1;
            entry_in = push_entry;
         end
      end else if (ctrl.push && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         entry_in = push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

/* src/ort_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Outstanding request tracker checker
// Port-level properties, bound to the tracker's top level.
// ----------------------------------------------------------------------------
`include "outstanding_request_tracker_defines.svh"

module ort_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_opcode,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [4:0]  rsp_out_instance_id,
   input logic [15:0] rsp_out_context,
   input logic        rsp_last
);

   // held result keeps its payload
   `ORT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_out_instance_id) && $stable(rsp_out_context), "stalled result changed")

   // no request taken while a result waits
   `ORT_ASSERT_NOW(a_req_blocked, clock, reset, rsp_valid && rsp_stall, req_stall, "request taken while result stalled")

   // a send answers in the next cycle
   `ORT_ASSERT_NEXT(a_send_latency, clock, reset, req_valid && !req_stall && req_opcode == ort_pkg::OP_SEND, rsp_valid && rsp_last, "send result missing")

   // only expiries come in groups
   `ORT_ASSERT_NOW(a_single_last, clock, reset, rsp_valid && rsp_status != ort_pkg::STATUS_EXPIRED, rsp_last, "non-expiry result without last")

endmodule

bind outstanding_request_tracker ort_checker u_ort_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_opcode          (req_opcode),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_out_instance_id (rsp_out_instance_id),
   .rsp_out_context     (rsp_out_context),
   .rsp_last            (rsp_last)
);
